// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk and switched off while rst is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Concurrent assertion sampled on clk that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ===== hdl/sgb_pkg.sv =====
// Package with the types and constants of the sliding Goertzel bin power block.
`timescale 1ns / 1ps
`default_nettype none

package sgb_pkg;

   localparam int SAMPLE_W = 12;
   localparam int COEF_W   = 16;
   localparam int STATE_W  = 32;
   localparam int POWER_W  = 63;
   localparam int FRAC_W   = 14;

   localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RES_MUL,
      ST_RES_UPD,
      ST_SQ1,
      ST_SQ2,
      ST_CROSS,
      ST_TLO,
      ST_THI,
      ST_TSUM,
      ST_POWER
   } sgb_state_type;

   typedef struct packed {
      logic                rd;
      logic                wr;
      logic [SAMPLE_W-1:0] wr_data;
   } sgb_win_req_type;

   typedef struct packed {
      logic [POWER_W-1:0] power;
      logic               sat;
   } sgb_result_type;

endpackage

`default_nettype wire

// ===== hdl/sgb_mul.sv =====
// Shared 32 by 32 bit unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module sgb_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] prod
);

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hdl/sgb_window.sv =====
// Sample delay line with its write position and a fill flag for unwritten entries.
`timescale 1ns / 1ps
`default_nettype none

module sgb_window #(
   parameter int WINDOW = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sgb_pkg::sgb_win_req_type        req,
   output logic [sgb_pkg::SAMPLE_W-1:0]         x_old
);

   localparam int PW = $clog2(WINDOW);

   logic [sgb_pkg::SAMPLE_W-1:0] mem [WINDOW];
   logic [PW-1:0]                pos_ff, pos_in;
   logic                         wrapped_ff, wrapped_in;
   logic [sgb_pkg::SAMPLE_W-1:0] rdata_ff;
   logic                         rvalid_ff;

   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (req.wr) begin
         if (pos_ff == PW'(WINDOW - 1)) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[pos_ff] <= req.wr_data;
      end
      if (req.rd) begin
         rdata_ff  <= mem[pos_ff];
         rvalid_ff <= wrapped_ff;
      end
   end

   assign x_old = rvalid_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

// ===== hdl/sgb_core.sv =====
// Sequencer and datapath that update the resonator and form the bin power.
`timescale 1ns / 1ps
`default_nettype none

module sgb_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [sgb_pkg::SAMPLE_W-1:0]        in_sample,
   input  wire logic signed [sgb_pkg::COEF_W-1:0]   coef,
   output sgb_pkg::sgb_win_req_type                 win_req,
   input  wire logic [sgb_pkg::SAMPLE_W-1:0]        x_old,
   output logic [31:0]                              mul_a,
   output logic [31:0]                              mul_b,
   input  wire logic [63:0]                         mul_prod,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output sgb_pkg::sgb_result_type                  out_result
);

   localparam int QW = 38;

   sgb_pkg::sgb_state_type state_ff, state_in;

   logic [sgb_pkg::SAMPLE_W-1:0]      x_ff, x_in;
   logic signed [sgb_pkg::STATE_W-1:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [63:0]                        s_ff, s_in;
   logic [31:0]                        cross_hi_ff, cross_hi_in;
   logic [47:0]                        tlo_ff, tlo_in;
   logic [63:0]                        t_ff, t_in;
   logic                               neg_ff, neg_in;
   logic                               sat_ff, sat_in;

   logic                               c_neg;
   logic [sgb_pkg::COEF_W-1:0]         cmag;
   logic [31:0]                        m1, m2;
   logic [48:0]                        pm_sum;
   logic [34:0]                        pm;
   logic signed [QW-1:0]               term, q0;
   logic signed [sgb_pkg::STATE_W-1:0] q0s;
   logic                               q0_sat;
   logic [79:0]                        t_total;
   logic [64:0]                        sum, diff;
   logic [sgb_pkg::POWER_W-1:0]        p;
   logic                               p_sat;

   assign c_neg = coef[sgb_pkg::COEF_W-1];
   assign cmag  = c_neg ? sgb_pkg::COEF_W'(-coef) : sgb_pkg::COEF_W'(coef);
   assign m1    = q1_ff[31] ? 32'(32'd0 - 32'(q1_ff)) : 32'(q1_ff);
   assign m2    = q2_ff[31] ? 32'(32'd0 - 32'(q2_ff)) : 32'(q2_ff);

   always_comb begin
      pm_sum = {1'b0, mul_prod[47:0]} + 49'd8192;
      pm     = pm_sum[48:sgb_pkg::FRAC_W];
      term   = (c_neg ^ q1_ff[31]) ? -QW'(signed'({1'b0, pm})) : QW'(signed'({1'b0, pm}));
      q0     = term - QW'(q2_ff) + QW'(signed'({1'b0, x_ff}))
               - QW'(signed'({1'b0, x_old}));
      q0_sat = 1'b1;
      if (q0 > QW'(signed'(32'sh7FFF_FFFF))) begin
         q0s = 32'sh7FFF_FFFF;
      end else if (q0 < QW'(signed'(32'sh8000_0000))) begin
         q0s = 32'sh8000_0000;
      end else begin
         q0s    = q0[31:0];
         q0_sat = 1'b0;
      end
   end

   always_comb begin
      t_total = {mul_prod[47:0], 32'd0} + {32'd0, tlo_ff} + 80'd8192;
      sum     = {1'b0, s_ff} + {1'b0, t_ff};
      diff    = {1'b0, s_ff} - {1'b0, t_ff};
      p_sat   = 1'b0;
      if (neg_ff) begin
         if (sum[64:63] != 2'b00) begin
            p     = sgb_pkg::POWER_MAX;
            p_sat = 1'b1;
         end else begin
            p = sum[62:0];
         end
      end else if (diff[64]) begin
         p = '0;
      end else if (diff[63]) begin
         p     = sgb_pkg::POWER_MAX;
         p_sat = 1'b1;
      end else begin
         p = diff[62:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      q1_in       = q1_ff;
      q2_in       = q2_ff;
      s_in        = s_ff;
      cross_hi_in = cross_hi_ff;
      tlo_in      = tlo_ff;
      t_in        = t_ff;
      neg_in      = neg_ff;
      sat_in      = sat_ff;
      in_ready    = 1'b0;
      out_valid   = 1'b0;
      win_req     = '{rd: 1'b0, wr: 1'b0, wr_data: x_ff};
      mul_a       = '0;
      mul_b       = '0;
      unique case (state_ff)
         sgb_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               x_in       = in_sample;
               win_req.rd = 1'b1;
               state_in   = sgb_pkg::ST_RES_MUL;
            end
         end
         sgb_pkg::ST_RES_MUL: begin
            mul_a    = {16'd0, cmag};
            mul_b    = m1;
            state_in = sgb_pkg::ST_RES_UPD;
         end
         sgb_pkg::ST_RES_UPD: begin
            q1_in      = q0s;
            q2_in      = q1_ff;
            sat_in     = q0_sat;
            neg_in     = (c_neg ^ q0s[31] ^ q1_ff[31]) && (q0s != '0) && (q1_ff != '0)
                         && (cmag != '0);
            win_req.wr = 1'b1;
            state_in   = sgb_pkg::ST_SQ1;
         end
         sgb_pkg::ST_SQ1: begin
            mul_a    = m1;
            mul_b    = m1;
            state_in = sgb_pkg::ST_SQ2;
         end
         sgb_pkg::ST_SQ2: begin
            mul_a    = m2;
            mul_b    = m2;
            s_in     = mul_prod;
            state_in = sgb_pkg::ST_CROSS;
         end
         sgb_pkg::ST_CROSS: begin
            mul_a    = m1;
            mul_b    = m2;
            s_in     = s_ff + mul_prod;
            state_in = sgb_pkg::ST_TLO;
         end
         sgb_pkg::ST_TLO: begin
            mul_a       = {16'd0, cmag};
            mul_b       = mul_prod[31:0];
            cross_hi_in = mul_prod[63:32];
            state_in    = sgb_pkg::ST_THI;
         end
         sgb_pkg::ST_THI: begin
            mul_a    = {16'd0, cmag};
            mul_b    = cross_hi_ff;
            tlo_in   = mul_prod[47:0];
            state_in = sgb_pkg::ST_TSUM;
         end
         sgb_pkg::ST_TSUM: begin
            t_in     = t_total[77:sgb_pkg::FRAC_W];
            state_in = sgb_pkg::ST_POWER;
         end
         sgb_pkg::ST_POWER: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = sgb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgb_pkg::ST_IDLE;
         end
      endcase
   end

   assign out_result = '{power: p, sat: sat_ff | p_sat};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgb_pkg::ST_IDLE;
         q1_ff    <= '0;
         q2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         q1_ff    <= q1_in;
         q2_ff    <= q2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      s_ff        <= s_in;
      cross_hi_ff <= cross_hi_in;
      tlo_ff      <= tlo_in;
      t_ff        <= t_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
   end

endmodule

`default_nettype wire

// ===== hdl/sliding_goertzel_bin_power_top.sv =====
// Top level of the sliding single-bin Goertzel power detector.
// The req channel takes one 12-bit converter sample per beat. Each sample
// updates a two-state resonator with the difference between the new sample
// and the one that leaves the window, and the rsp channel returns one beat
// with the bin power and a saturation flag for every sample.
// The csr port writes the signed Q2.14 coefficient; write it only while no
// sample is in flight.
// One sample passes from acceptance to the result register entirely in a
// sequencer that reuses one registered 32 by 32 multiplier for six products
// in turn. req_tready is high only while the sequencer is idle, so the block
// takes no new sample until the last one has moved to the output register.
// A finished result sits in the output register; the next sample is accepted
// and processed meanwhile, and its result waits in the sequencer until the
// receiver takes the earlier beat.
// Reset clears the resonator, the write position, the coefficient and the
// output valid flag. Window entries not yet written since reset read as zero.
`timescale 1ns / 1ps
`default_nettype none

module sliding_goertzel_bin_power_top #(
   parameter int WINDOW = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [62:0] bin_power
   output logic             rsp_tuser,   // [0] saturated
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data  // [15:0] bin_coefficient
);

   logic signed [sgb_pkg::COEF_W-1:0] coef_ff;
   sgb_pkg::sgb_win_req_type          win_req;
   logic [sgb_pkg::SAMPLE_W-1:0]      x_old;
   logic [31:0]                       mul_a, mul_b;
   logic [63:0]                       mul_prod;
   logic                              core_valid, core_ready;
   sgb_pkg::sgb_result_type           core_result;
   logic                              rsp_valid_ff;
   sgb_pkg::sgb_result_type           rsp_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_wr_en) begin
         coef_ff <= signed'(csr_wr_data);
      end
   end

   sgb_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   sgb_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .req   (win_req),
      .x_old (x_old)
   );

   sgb_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata[sgb_pkg::SAMPLE_W-1:0]),
      .coef       (coef_ff),
      .win_req    (win_req),
      .x_old      (x_old),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_prod   (mul_prod),
      .out_valid  (core_valid),
      .out_ready  (core_ready),
      .out_result (core_result)
   );

   assign core_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_ready) begin
         rsp_valid_ff <= core_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (core_ready && core_valid) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_result_ff.power};
   assign rsp_tuser  = rsp_result_ff.sat;

endmodule

`default_nettype wire

// ===== hdl/sgb_checker.sv =====
// Port-level checker for the sliding Goertzel bin power block and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sgb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   `ASSERT_CLK_ALWAYS(a_reset_empties_output, clock, reset |=> !rsp_tvalid)
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `ASSERT_CLK(a_result_from_busy, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tready))
   `ASSERT_CLK(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind sliding_goertzel_bin_power_top sgb_checker u_sgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== test/tb_sliding_goertzel_bin_power_top.sv =====
// Self-checking testbench that streams samples through the sliding Goertzel detector.
`timescale 1ns / 1ps

module tb_sliding_goertzel_bin_power_top;

   localparam int WINDOW = 64;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int RANDOM_SETTINGS = 8;
   localparam int ITEMS_PER_SETTING = 180;
   localparam int CHASE_ITEMS = 256;
   localparam longint STATE_HIGH = 64'sd2147483647;
   localparam longint STATE_LOW = -64'sd2147483648;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = 16'd0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   logic [sgb_pkg::SAMPLE_W-1:0] pending_samples[$];
   sgb_pkg::sgb_result_type expected_bins[$];

   longint coefficient_now;
   longint latest_state;
   longint previous_state;
   logic [sgb_pkg::SAMPLE_W-1:0] window_copy [0:WINDOW-1];
   int write_slot;

   logic req_beat_taken = 1'b0;
   logic idling_on = 1'b1;
   int send_gap = 0;
   int recv_stall = 0;
   int mismatch_count = 0;
   int samples_taken = 0;
   int clipped_results = 0;
   int settings_count = 0;
   int cycle_count = 0;

   sliding_goertzel_bin_power_top #(
      .WINDOW(WINDOW)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Magnitude times |coefficient| over 2^14, rounded half away from zero.
   function automatic logic [63:0] round_product(input logic [63:0] coef_mag,
                                                  input logic [63:0] value);
      logic [127:0] wide;
      wide = {64'd0, coef_mag} * {64'd0, value} + 128'd8192;
      return wide[77:14];
   endfunction

   function automatic sgb_pkg::sgb_result_type goertzel_step(
      input logic [sgb_pkg::SAMPLE_W-1:0] sample);
      sgb_pkg::sgb_result_type outcome;
      longint coef_abs;
      longint latest_abs;
      longint scaled;
      longint next_state;
      longint x_new;
      longint x_leaving;
      logic [63:0] mag_new;
      logic [63:0] mag_old;
      logic [63:0] tone_energy;
      logic [63:0] cross_term;
      logic [127:0] power_wide;
      logic cross_adds;
      outcome.sat = 1'b0;
      coef_abs = (coefficient_now < 0) ? -coefficient_now : coefficient_now;
      latest_abs = (latest_state < 0) ? -latest_state : latest_state;
      scaled = round_product(coef_abs, latest_abs);
      if ((coefficient_now < 0) != (latest_state < 0)) scaled = -scaled;
      x_new = longint'(sample);
      x_leaving = longint'(window_copy[write_slot]);
      next_state = scaled - previous_state + x_new - x_leaving;
      if (next_state > STATE_HIGH) begin
         next_state = STATE_HIGH;
         outcome.sat = 1'b1;
      end
      if (next_state < STATE_LOW) begin
         next_state = STATE_LOW;
         outcome.sat = 1'b1;
      end
      previous_state = latest_state;
      latest_state = next_state;
      window_copy[write_slot] = sample;
      write_slot = (write_slot + 1) % WINDOW;

      mag_new = (latest_state < 0) ? -latest_state : latest_state;
      mag_old = (previous_state < 0) ? -previous_state : previous_state;
      tone_energy = mag_new * mag_new + mag_old * mag_old;
      cross_term = round_product(coef_abs, mag_new * mag_old);
      cross_adds = ((coefficient_now < 0) != ((latest_state < 0) != (previous_state < 0)))
                   && mag_new != 0 && mag_old != 0 && coef_abs != 0;
      if (cross_adds) begin
         power_wide = {64'd0, tone_energy} + {64'd0, cross_term};
      end else begin
         power_wide = (cross_term > tone_energy) ? 128'd0
                      : {64'd0, tone_energy - cross_term};
      end
      if (power_wide > {65'd0, sgb_pkg::POWER_MAX}) begin
         outcome.power = sgb_pkg::POWER_MAX;
         outcome.sat = 1'b1;
      end else begin
         outcome.power = power_wide[sgb_pkg::POWER_W-1:0];
      end
      return outcome;
   endfunction

   always @(negedge clock) begin : drive_beats
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_beat_taken) begin
            if (send_gap != 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_tdata <= {4'b0000, pending_samples.pop_front()};
               req_tvalid <= 1'b1;
               if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (recv_stall != 0) begin
            recv_stall = recv_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 7);
         end
      end
   end

   always @(posedge clock) begin : watch_beats
      sgb_pkg::sgb_result_type want;
      sgb_pkg::sgb_result_type predicted;
      if (reset) begin
         req_beat_taken = 1'b0;
      end else begin
         req_beat_taken = req_tvalid && req_tready;
         if (req_beat_taken) begin
            predicted = goertzel_step(req_tdata[sgb_pkg::SAMPLE_W-1:0]);
            expected_bins.push_back(predicted);
            samples_taken++;
            if (predicted.sat) clipped_results++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bins.size() == 0) begin
               $display("%0t: result beat with nothing expected, power %0d sat %0b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = expected_bins.pop_front();
               if (rsp_tdata !== {1'b0, want.power}) begin
                  $display("%0t: bin_power expected %0d actual %0d",
                           $time, want.power, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.sat) begin
                  $display("%0t: saturated expected %0b actual %0b", $time, want.sat, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timed out with %0d results outstanding", $time, expected_bins.size());
      $display("FAIL sliding_goertzel_bin_power_top");
      $finish;
   end

   task automatic wait_for_idle;
      while (pending_samples.size() != 0 || req_tvalid || expected_bins.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coefficient(input logic signed [15:0] value);
      wait_for_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      coefficient_now = longint'(value);
      settings_count++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int setting;
      int n;
      int tone_bin;
      int pushed;
      real phase_angle;
      logic signed [15:0] coef_pick;
      coefficient_now = 0;
      latest_state = 0;
      previous_state = 0;
      write_slot = 0;
      for (n = 0; n < WINDOW; n++) window_copy[n] = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      pending_samples.push_back(12'd0);
      pending_samples.push_back(12'd4095);
      pending_samples.push_back(12'hAAA);
      pending_samples.push_back(12'h555);

      write_coefficient(16'sd8192);
      pending_samples.push_back(12'd1);
      pending_samples.push_back(12'd3);
      pending_samples.push_back(12'd5);
      pending_samples.push_back(12'd4095);

      write_coefficient(-16'sd8192);
      pending_samples.push_back(12'd1);
      pending_samples.push_back(12'd3);
      pending_samples.push_back(12'd4094);

      write_coefficient(-16'sd32768);
      for (n = 0; n < 5; n++) pending_samples.push_back(n % 2 == 0 ? 12'd4095 : 12'd0);

      write_coefficient(16'sd32767);
      pending_samples.push_back(12'd4095);
      pending_samples.push_back(12'd4095);
      pending_samples.push_back(12'd4095);
      pending_samples.push_back(12'd0);
      pending_samples.push_back(12'd0);

      for (setting = 0; setting < RANDOM_SETTINGS; setting++) begin
         tone_bin = $urandom_range(1, 32);
         case ($urandom_range(0, 3))
            0: coef_pick = 16'($urandom);
            1: coef_pick = 16'($rtoi(32768.0 * $cos(2.0 * 3.14159265358979 * tone_bin / 64.0)));
            2: coef_pick = ($urandom_range(0, 1) == 0) ? -16'sd32768 : 16'sd32767;
            default: coef_pick = $signed(16'($urandom_range(0, 511))) - 16'sd256;
         endcase
         write_coefficient(coef_pick);
         for (n = 0; n < ITEMS_PER_SETTING; n++) begin
            case ($urandom_range(0, 3))
               0, 1: begin
                  phase_angle = 2.0 * 3.14159265358979 * tone_bin * n / 64.0;
                  pending_samples.push_back(12'(2048 + $rtoi(2000.0 * $cos(phase_angle))));
               end
               2: pending_samples.push_back(12'($urandom_range(0, 4095)));
               default: pending_samples.push_back($urandom_range(0, 1) == 0 ? 12'd0 : 12'd4095);
            endcase
         end
      end

      // A coefficient of -2 with a Nyquist-rate input keeps growing the resonator.
      idling_on = 1'b0;
      write_coefficient(-16'sd32768);
      pushed = 0;
      while (clipped_results < 64 && pushed < CHASE_ITEMS) begin
         for (n = 0; n < 64; n++) pending_samples.push_back(n % 2 == 0 ? 12'd4095 : 12'd0);
         pushed += 64;
         while (pending_samples.size() > 32) @(posedge clock);
      end

      write_coefficient(16'sd32767);
      for (n = 0; n < 128; n++) pending_samples.push_back(12'($urandom_range(0, 4095)));
      write_coefficient(16'sd0);
      for (n = 0; n < 64; n++) pending_samples.push_back(12'($urandom_range(0, 4095)));

      wait_for_idle();
      $display("Streamed %0d samples under %0d coefficient writes; %0d results clipped.",
               samples_taken, settings_count, clipped_results);
      $display("Mismatches found: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS sliding_goertzel_bin_power_top");
      end else begin
         $display("FAIL sliding_goertzel_bin_power_top");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sgb_pkg.sv
hdl/sgb_mul.sv
hdl/sgb_window.sv
hdl/sgb_core.sv
hdl/sliding_goertzel_bin_power_top.sv
hdl/sgb_checker.sv
test/tb_sliding_goertzel_bin_power_top.sv
